FILE: src/tpn_pkg.sv
// ----------------------------------------------------------------------------
// tpn_pkg
// Types and constants for the triangle unit face normal pipeline.
// ----------------------------------------------------------------------------
package tpn_pkg;

    localparam int CW  = 16;              // coordinate width, Q4.12
    localparam int FB  = 14;              // normal fraction bits, Q2.14
    localparam int EW  = CW + 1;          // edge vector width
    localparam int NW  = 2 * EW + 1;      // cross product component width
    localparam int SQW = 2 * NW + 2;      // squared length width
    localparam int RW  = 2 * NW + 2 * FB + 6;  // root remainder width
    localparam int QW  = FB + 1;          // quotient magnitude width
    localparam int OW  = FB + 2;          // output component width
    localparam int FRONT_STAGES = 5;

    typedef struct packed {
        logic signed [CW-1:0] p0_x;
        logic signed [CW-1:0] p0_y;
        logic signed [CW-1:0] p0_z;
        logic signed [CW-1:0] p1_x;
        logic signed [CW-1:0] p1_y;
        logic signed [CW-1:0] p1_z;
        logic signed [CW-1:0] p2_x;
        logic signed [CW-1:0] p2_y;
        logic signed [CW-1:0] p2_z;
    } pts_t;

    typedef struct packed {
        logic signed [OW-1:0] normal_x;
        logic signed [OW-1:0] normal_y;
        logic signed [OW-1:0] normal_z;
    } nrm_t;

    typedef struct packed {
        logic [RW-1:0] r;
        logic [RW-1:0] p;
        logic [QW-1:0] q;
        logic          neg;
    } lane_t;

    typedef struct packed {
        lane_t [2:0]    lane;
        logic [SQW-1:0] sq;
        logic           zero;
    } root_t;

endpackage

FILE: src/tpn_front.sv
// ----------------------------------------------------------------------------
// tpn_front
// Edge vectors, cross product, squared length and root setup (5 stages).
// ----------------------------------------------------------------------------
module tpn_front
(
    input  logic                                 clk,
    input  logic [tpn_pkg::FRONT_STAGES-1:0]     en,
    input  tpn_pkg::pts_t                        pts,
    output tpn_pkg::root_t                       res
);

    localparam int U [3] = '{1, 2, 0};
    localparam int V [3] = '{2, 0, 1};

    logic signed [tpn_pkg::CW-1:0]     a [3];
    logic signed [tpn_pkg::CW-1:0]     b [3];
    logic signed [tpn_pkg::CW-1:0]     c [3];
    logic signed [tpn_pkg::EW-1:0]     e1_reg [3];
    logic signed [tpn_pkg::EW-1:0]     e2_reg [3];
    logic signed [2*tpn_pkg::EW-1:0]   t0_reg [3];
    logic signed [2*tpn_pkg::EW-1:0]   t1_reg [3];
    logic signed [tpn_pkg::NW-1:0]     n_reg [3];
    logic [2*tpn_pkg::NW-1:0]          nsq_reg [3];
    logic [2:0]                        neg_reg;
    tpn_pkg::root_t                    res_reg;

    always_comb
    begin
        a[0] = pts.p0_x;  a[1] = pts.p0_y;  a[2] = pts.p0_z;
        b[0] = pts.p1_x;  b[1] = pts.p1_y;  b[2] = pts.p1_z;
        c[0] = pts.p2_x;  c[1] = pts.p2_y;  c[2] = pts.p2_z;
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 3; k++)
        begin
            if (en[0])
            begin
                e1_reg[k] <= tpn_pkg::EW'(a[k]) - tpn_pkg::EW'(b[k]);
                e2_reg[k] <= tpn_pkg::EW'(b[k]) - tpn_pkg::EW'(c[k]);
            end
            if (en[1])
            begin
                t0_reg[k] <= e1_reg[U[k]] * e2_reg[V[k]];
                t1_reg[k] <= e1_reg[V[k]] * e2_reg[U[k]];
            end
            if (en[2])
                n_reg[k] <= tpn_pkg::NW'(t0_reg[k]) - tpn_pkg::NW'(t1_reg[k]);
            if (en[3])
            begin
                nsq_reg[k] <= n_reg[k] * n_reg[k];
                neg_reg[k] <= n_reg[k][tpn_pkg::NW-1];
            end
        end
        if (en[4])
        begin
            res_reg.sq   <= tpn_pkg::SQW'(nsq_reg[0]) + tpn_pkg::SQW'(nsq_reg[1])
                          + tpn_pkg::SQW'(nsq_reg[2]);
            res_reg.zero <= (nsq_reg[0] | nsq_reg[1] | nsq_reg[2]) == '0;
            for (int k = 0; k < 3; k++)
            begin
                res_reg.lane[k].r   <= tpn_pkg::RW'(nsq_reg[k]) << (2 * tpn_pkg::FB);
                res_reg.lane[k].p   <= '0;
                res_reg.lane[k].q   <= '0;
                res_reg.lane[k].neg <= neg_reg[k];
            end
        end
    end

    assign res = res_reg;

endmodule

FILE: src/tpn_root_step.sv
// ----------------------------------------------------------------------------
// tpn_root_step
// One quotient bit of n_i * 2^FB / |n| for all three lanes, no divider:
// tries q + 2^BIT against q^2 * |n|^2 <= n_i^2 * 2^(2FB).
// ----------------------------------------------------------------------------
module tpn_root_step
#(
    parameter int BIT = 0
)
(
    input  logic           clk,
    input  logic           en,
    input  tpn_pkg::root_t din,
    output tpn_pkg::root_t dout
);

    logic [tpn_pkg::RW-1:0] sq_w;
    logic [tpn_pkg::RW-1:0] delta [3];
    tpn_pkg::root_t         res_next;
    tpn_pkg::root_t         res_reg;

    always_comb
    begin
        sq_w     = tpn_pkg::RW'(din.sq);
        res_next = din;
        for (int k = 0; k < 3; k++)
        begin
            delta[k] = (din.lane[k].p << (BIT + 1)) + (sq_w << (2 * BIT));
            if (delta[k] <= din.lane[k].r)
            begin
                res_next.lane[k].r      = din.lane[k].r - delta[k];
                res_next.lane[k].p      = din.lane[k].p + (sq_w << BIT);
                res_next.lane[k].q[BIT] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
            res_reg <= res_next;
    end

    assign dout = res_reg;

endmodule

FILE: src/three_point_unit_normal.sv
// ----------------------------------------------------------------------------
// three_point_unit_normal
// Unit face normal of a triangle given as three Q4.12 points.
// ----------------------------------------------------------------------------
// Input channel pts_valid / pts_ready / pts carries one triangle per item.
// Output channel nrm_valid / nrm_ready / nrm carries the Q2.14 unit normal,
// each component truncated toward zero; a degenerate triangle gives zeros.
// There are 21 register stages from acceptance to nrm_valid,
// the first loaded at the accepting edge. One stage each for the edge
// vectors, products, cross product, squares and squared length,
// one stage per quotient bit (15) and the output register.
// Throughput is one item per cycle while nrm_ready is high; the 15
// bit-serial root stages are unrolled so every stage holds its own item.
// Each stage has its own valid bit and loads whenever it is empty or the
// stage after it moves, so bubbles are squeezed out while nrm_ready is low
// and pts_ready stays high until every stage is full.
// Reset clears all valid bits; the pipeline is empty afterwards.
// ----------------------------------------------------------------------------
module three_point_unit_normal
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           pts_valid,
    output logic           pts_ready,
    input  tpn_pkg::pts_t  pts,
    output logic           nrm_valid,
    input  logic           nrm_ready,
    output tpn_pkg::nrm_t  nrm
);

    localparam int NS = tpn_pkg::FRONT_STAGES + tpn_pkg::QW + 1;

    logic [NS-1:0]   v_reg;
    logic [NS-1:0]   v_next;
    logic [NS-1:0]   en;
    tpn_pkg::root_t  rs [tpn_pkg::QW+1];
    tpn_pkg::nrm_t   nrm_reg;
    tpn_pkg::nrm_t   nrm_next;
    logic signed [tpn_pkg::OW-1:0] comp [3];

    always_comb
    begin
        en[NS-1] = !v_reg[NS-1] || nrm_ready;
        for (int k = NS - 2; k >= 0; k--)
            en[k] = !v_reg[k] || en[k+1];
        v_next[0] = en[0] ? pts_valid : v_reg[0];
        for (int k = 1; k < NS; k++)
            v_next[k] = en[k] ? v_reg[k-1] : v_reg[k];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
            v_reg <= v_next;
    end

    tpn_front u_front
    (
        .clk (clk),
        .en  (en[tpn_pkg::FRONT_STAGES-1:0]),
        .pts (pts),
        .res (rs[0])
    );

    for (genvar i = 0; i < tpn_pkg::QW; i++)
    begin : g_root
        tpn_root_step
        #(
            .BIT (tpn_pkg::FB - i)
        )
        u_step
        (
            .clk  (clk),
            .en   (en[tpn_pkg::FRONT_STAGES + i]),
            .din  (rs[i]),
            .dout (rs[i+1])
        );
    end

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            if (rs[tpn_pkg::QW].zero)
                comp[k] = '0;
            else if (rs[tpn_pkg::QW].lane[k].neg)
                comp[k] = -$signed(tpn_pkg::OW'(rs[tpn_pkg::QW].lane[k].q));
            else
                comp[k] = $signed(tpn_pkg::OW'(rs[tpn_pkg::QW].lane[k].q));
        end
        nrm_next.normal_x = comp[0];
        nrm_next.normal_y = comp[1];
        nrm_next.normal_z = comp[2];
    end

    always_ff @(posedge clk)
    begin
        if (en[NS-1])
            nrm_reg <= nrm_next;
    end

    assign pts_ready = en[0];
    assign nrm_valid = v_reg[NS-1];
    assign nrm       = nrm_reg;

endmodule

FILE: tb/tb_three_point_unit_normal.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_three_point_unit_normal
// Self-checking bench for the triangle unit face normal pipeline.
// ----------------------------------------------------------------------------
// Triangles go in on the pts channel; a local exact model computes the
// truncated Q2.14 normal of each accepted item and the checker compares it
// with every result leaving on the nrm channel, oldest first. Covers
// extreme coordinates, axis-aligned and degenerate triangles, random
// triangles under sender and receiver idling, and a long output stall.
// ----------------------------------------------------------------------------
module tb_three_point_unit_normal;

    localparam int  LATENCY   = 20;
    localparam longint LIMIT  = 400000;

    logic           clk;
    logic           rst_n;
    logic           pts_valid;
    logic           pts_ready;
    tpn_pkg::pts_t  pts;
    logic           nrm_valid;
    logic           nrm_ready;
    tpn_pkg::nrm_t  nrm;

    tpn_pkg::nrm_t  normal_q[$];
    int     errors;
    int     send_idle_pct;
    int     recv_idle_pct;
    int     hold_cycles;
    longint cycle_count;

    three_point_unit_normal u_top
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .pts_valid (pts_valid),
        .pts_ready (pts_ready),
        .pts       (pts),
        .nrm_valid (nrm_valid),
        .nrm_ready (nrm_ready),
        .nrm       (nrm)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > LIMIT)
            begin
                $display("FAIL three_point_unit_normal");
                $finish;
            end
        end
    end

    // exact truncated component: largest q with q*q*sq <= ni*ni*2^(2*FB)
    function automatic logic signed [tpn_pkg::OW-1:0] unit_part(
        logic signed [127:0] ni, logic [127:0] sq);
        logic [127:0] mag;
        logic [255:0] goal;
        logic [255:0] lhs;
        logic [tpn_pkg::QW-1:0] q;
        logic [tpn_pkg::QW-1:0] c;
        mag  = ni[127] ? -ni : ni;
        goal = ({128'd0, mag} * {128'd0, mag}) << (2 * tpn_pkg::FB);
        q = '0;
        for (int b = tpn_pkg::FB; b >= 0; b--)
        begin
            c = q | (tpn_pkg::QW'(1) << b);
            lhs = {241'd0, c} * {241'd0, c} * {128'd0, sq};
            if (lhs <= goal) q = c;
        end
        return ni[127] ? -$signed({1'b0, q}) : $signed({1'b0, q});
    endfunction

    function automatic tpn_pkg::nrm_t face_normal(tpn_pkg::pts_t p);
        logic signed [127:0] e1 [3];
        logic signed [127:0] e2 [3];
        logic signed [127:0] n [3];
        logic [127:0] sq;
        tpn_pkg::nrm_t r;
        e1[0] = 128'(p.p0_x) - 128'(p.p1_x);
        e1[1] = 128'(p.p0_y) - 128'(p.p1_y);
        e1[2] = 128'(p.p0_z) - 128'(p.p1_z);
        e2[0] = 128'(p.p1_x) - 128'(p.p2_x);
        e2[1] = 128'(p.p1_y) - 128'(p.p2_y);
        e2[2] = 128'(p.p1_z) - 128'(p.p2_z);
        for (int k = 0; k < 3; k++)
            n[k] = e1[(k+1)%3] * e2[(k+2)%3] - e1[(k+2)%3] * e2[(k+1)%3];
        sq = n[0] * n[0] + n[1] * n[1] + n[2] * n[2];
        if (sq == 0)
            r = '0;
        else
        begin
            r.normal_x = unit_part(n[0], sq);
            r.normal_y = unit_part(n[1], sq);
            r.normal_z = unit_part(n[2], sq);
        end
        return r;
    endfunction

    function automatic tpn_pkg::pts_t rand_bits();
        return tpn_pkg::pts_t'({$urandom, $urandom, $urandom, $urandom, 16'($urandom)});
    endfunction

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_triangle(tpn_pkg::pts_t p);
        while ($urandom_range(99) < send_idle_pct)
        begin
            pts_valid <= 1'b0;
            pts       <= rand_bits();
            @(negedge clk);
        end
        pts_valid <= 1'b1;
        pts       <= p;
        @(posedge clk);
        while (!pts_ready) @(posedge clk);
        normal_q.push_back(face_normal(p));
        @(negedge clk);
    endtask

    // receiver: random idling, or a long counted hold-off when requested
    initial
    begin
        nrm_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                nrm_ready <= 1'b0;
                hold_cycles--;
            end
            else
                nrm_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial
    begin
        tpn_pkg::nrm_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && nrm_valid && nrm_ready)
            begin
                if (normal_q.size() == 0)
                begin
                    errors++;
                    if (errors <= 10) $display("unexpected normal %h", nrm);
                end
                else
                begin
                    want = normal_q.pop_front();
                    if (nrm !== want)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display("mismatch: exp %0d %0d %0d got %0d %0d %0d",
                                     want.normal_x, want.normal_y, want.normal_z,
                                     nrm.normal_x, nrm.normal_y, nrm.normal_z);
                    end
                end
            end
        end
    end

    function automatic tpn_pkg::pts_t make_pts(int ax, int ay, int az, int bx, int by,
                                               int bz, int cx, int cy, int cz);
        tpn_pkg::pts_t p;
        p.p0_x = tpn_pkg::CW'(ax); p.p0_y = tpn_pkg::CW'(ay); p.p0_z = tpn_pkg::CW'(az);
        p.p1_x = tpn_pkg::CW'(bx); p.p1_y = tpn_pkg::CW'(by); p.p1_z = tpn_pkg::CW'(bz);
        p.p2_x = tpn_pkg::CW'(cx); p.p2_y = tpn_pkg::CW'(cy); p.p2_z = tpn_pkg::CW'(cz);
        return p;
    endfunction

    function automatic int rand_coord();
        case ($urandom_range(5))
            0: return $urandom_range(1) ? 32767 : -32768;
            1: return int'($urandom_range(16)) - 8;
            default: return int'($urandom_range(65535)) - 32768;
        endcase
    endfunction

    function automatic tpn_pkg::pts_t rand_triangle();
        tpn_pkg::pts_t p;
        p = rand_bits();
        case ($urandom_range(9))
            0: p.p1_x = p.p0_x;
            1:
            begin
                p.p2_x = p.p1_x;
                p.p2_y = p.p1_y;
                p.p2_z = p.p1_z;
            end
            default: ;
        endcase
        return p;
    endfunction

    task automatic test_directed();
        send_triangle(make_pts(0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_triangle(make_pts(100, 200, 300, 100, 200, 300, 5, 6, 7));
        send_triangle(make_pts(0, 0, 0, 1, 1, 1, 2, 2, 2));
        send_triangle(make_pts(0, 0, 0, 4096, 0, 0, 4096, 4096, 0));
        send_triangle(make_pts(0, 0, 0, 0, 4096, 0, 4096, 4096, 0));
        send_triangle(make_pts(0, 0, 0, 0, 0, 4096, 0, 4096, 4096));
        send_triangle(make_pts(0, 0, 0, 4096, 0, 0, 4096, 0, 4096));
        send_triangle(make_pts(32767, 32767, 32767, -32768, -32768, -32768,
                               32767, -32768, 32767));
        send_triangle(make_pts(-32768, 32767, 0, 32767, -32768, 0, 0, 0, 32767));
        send_triangle(make_pts(32767, 0, 0, 0, 32767, 0, 0, 0, 32767));
        send_triangle(make_pts(-32768, 0, 0, 0, -32768, 0, 0, 0, -32768));
        send_triangle(make_pts(1, 0, 0, 0, 1, 0, 0, 0, 1));
        send_triangle(make_pts(0, 0, 0, 1, 0, 0, 0, 1, 0));
        send_triangle(make_pts(32767, -32768, 32767, -32768, 32767, -32768,
                               -32768, -32768, 32767));
        send_triangle(make_pts(-1, -1, -1, -1, -1, -1, -1, -1, -1));
        send_triangle(make_pts(1, 2, 3, 3, 2, 1, 1, 3, 2));
    endtask

    task automatic test_random(int count);
        tpn_pkg::pts_t p;
        for (int i = 0; i < count; i++)
        begin
            p = rand_triangle();
            if ($urandom_range(3) == 0)
                p = make_pts(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                             rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                             rand_coord());
            send_triangle(p);
        end
    endtask

    task automatic test_backpressure();
        hold_cycles = 200;
        test_random(60);
    endtask

    task automatic drain();
        pts_valid <= 1'b0;
        while (normal_q.size() != 0) @(posedge clk);
        repeat (LATENCY + 5) @(posedge clk);
    endtask

    initial
    begin
        errors        = 0;
        hold_cycles   = 0;
        send_idle_pct = 29;
        recv_idle_pct = 48;
        rst_n         = 1'b0;
        pts_valid     = 1'b0;
        pts           = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_directed();
        test_random(350);
        send_idle_pct = 48;
        recv_idle_pct = 29;
        test_random(350);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_backpressure();
        test_random(370);
        drain();
        if (errors == 0)
            $display("PASS three_point_unit_normal");
        else
            $display("FAIL three_point_unit_normal");
        $finish;
    end
endmodule

FILE: three_point_unit_normal.f
src/tpn_pkg.sv
src/tpn_front.sv
src/tpn_root_step.sv
src/three_point_unit_normal.sv
tb/tb_three_point_unit_normal.sv
